// ----- rtl/esd_pkg.sv -----
`timescale 1ns / 1ps
// Types, character codes and small helper functions for the escape sequence decoder.
// No dependencies.
package esd_pkg;

   typedef enum logic [3:0] {
      MODE_PLAIN = 4'b0001,
      MODE_ESC   = 4'b0010,
      MODE_U     = 4'b0100,
      MODE_X     = 4'b1000
   } mode_type;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_S         = 8'h73;

   localparam logic [7:0] CTL_BS    = 8'h08;
   localparam logic [7:0] CTL_TAB   = 8'h09;
   localparam logic [7:0] CTL_LF    = 8'h0A;
   localparam logic [7:0] CTL_CR    = 8'h0D;
   localparam logic [7:0] CTL_FF    = 8'h0C;
   localparam logic [7:0] CTL_SPACE = 8'h20;

   // code >> 10 for the high and low surrogate ranges
   localparam logic [10:0] SURR_HIGH_TOP = 11'h036;
   localparam logic [10:0] SURR_LOW_TOP  = 11'h037;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;

   localparam int          CODE_W   = 21;
   localparam int          MAX_OUT  = 4;
   localparam int          PEND_DEP = 3;

   typedef logic [2:0] count_type;

   // Hex digit value; anything else contributes its raw byte.
   function automatic logic [7:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c;
      end
      return v;
   endfunction

   function automatic logic [7:0] simple_escape(input logic [7:0] c);
      logic [7:0] v;
      unique case (c)
         CH_B:    v = CTL_BS;
         CH_T:    v = CTL_TAB;
         CH_N:    v = CTL_LF;
         CH_R:    v = CTL_CR;
         CH_F:    v = CTL_FF;
         CH_S:    v = CTL_SPACE;
         default: v = c;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/escape_sequence_decoder.sv -----
`timescale 1ns / 1ps
// Escape sequence decoder: backslash escapes, \xHH and \uHHHH (UTF-8 out).
// Single module; depends on esd_pkg.
//
// Usage
//   Request channel (req_*): one raw byte per request, req_last_byte marks the
//   final byte of a stream. Response channel (rsp_*): one decoded byte per
//   response; rsp_run_last flags the last byte produced by a request.
//   A request yields zero to four response bytes.
// Timing
//   A request is registered, then decoded into a four-byte response buffer;
//   its first byte is offered once that buffer is loaded from the input register.
//   One request per cycle is taken while each yields at most one byte and
//   rsp_stall is low; a request yielding N bytes holds the response buffer until
//   it drains one byte per cycle while rsp_stall is low. Requests that yield nothing never wait.
// Reset
//   Synchronous, active high: decoder returns to plain mode, no surrogate held,
//   both channels empty. After a last byte the decoder starts a fresh stream.
// Stall
//   rsp_stall freezes the response buffer; the input register then fills and
//   req_stall rises. No byte is dropped or repeated.
module escape_sequence_decoder
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;

   mode_type          mode_ff, mode_in;
   logic [1:0]        digit_cnt_ff, digit_cnt_in;
   logic [CODE_W-1:0] acc_ff, acc_in;
   logic [15:0]       held_ff, held_in;
   logic [7:0]        pend_ff [PEND_DEP];
   logic              pend_we;

   logic [7:0]        obuf_ff [MAX_OUT];
   count_type         ocnt_ff;

   logic [7:0]        dec_byte [MAX_OUT];
   count_type         dec_cnt;

   logic [7:0]        nib;
   logic [CODE_W-1:0] acc_sum, ucode;
   logic              is_high, is_low, do_join, is_u, need_met;
   logic [7:0]        u_byte [MAX_OUT];
   count_type         u_cnt;

   logic              buf_free, move, rsp_take;

   // ---------------- decode ----------------
   always_comb begin
      nib     = nibble_of(in_byte_ff);
      acc_sum = {acc_ff[CODE_W-5:0], 4'b0000} + {{(CODE_W-8){1'b0}}, nib};
      is_high = acc_sum[CODE_W-1:10] == SURR_HIGH_TOP;
      is_low  = acc_sum[CODE_W-1:10] == SURR_LOW_TOP;
      do_join = is_low && (held_ff != 16'h0000);
      ucode   = do_join ? ({1'b0, held_ff[9:0], acc_sum[9:0]} + SUPP_BASE) : acc_sum;
   end

   // UTF-8 form of ucode
   always_comb begin
      for (int i = 0; i < MAX_OUT; i++) begin
         u_byte[i] = 8'h00;
      end
      if (ucode[CODE_W-1:7] == '0) begin
         u_cnt     = 3'd1;
         u_byte[0] = ucode[7:0];
      end else if (ucode[CODE_W-1:11] == '0) begin
         u_cnt     = 3'd2;
         u_byte[0] = {3'b110, ucode[10:6]};
         u_byte[1] = {2'b10, ucode[5:0]};
      end else if (ucode[CODE_W-1:16] == '0) begin
         u_cnt     = 3'd3;
         u_byte[0] = {4'b1110, ucode[15:12]};
         u_byte[1] = {2'b10, ucode[11:6]};
         u_byte[2] = {2'b10, ucode[5:0]};
      end else begin
         u_cnt     = 3'd4;
         u_byte[0] = {5'b11110, ucode[20:18]};
         u_byte[1] = {2'b10, ucode[17:12]};
         u_byte[2] = {2'b10, ucode[11:6]};
         u_byte[3] = {2'b10, ucode[5:0]};
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      digit_cnt_in = digit_cnt_ff;
      acc_in       = acc_ff;
      held_in      = held_ff;
      pend_we      = 1'b0;
      dec_cnt      = 3'd0;
      for (int i = 0; i < MAX_OUT; i++) begin
         dec_byte[i] = 8'h00;
      end
      is_u     = mode_ff == MODE_U;
      need_met = is_u ? (digit_cnt_ff == 2'd3) : (digit_cnt_ff != 2'd0);

      unique case (mode_ff)
         MODE_PLAIN: begin
            if (in_byte_ff == CH_BACKSLASH && !in_last_ff) begin
               mode_in = MODE_ESC;
            end else begin
               held_in     = 16'h0000;
               dec_cnt     = 3'd1;
               dec_byte[0] = in_byte_ff;
            end
         end
         MODE_ESC: begin
            if ((in_byte_ff == CH_U || in_byte_ff == CH_X) && !in_last_ff) begin
               mode_in      = (in_byte_ff == CH_U) ? MODE_U : MODE_X;
               digit_cnt_in = 2'd0;
               acc_in       = '0;
            end else begin
               held_in     = 16'h0000;
               dec_cnt     = 3'd1;
               dec_byte[0] = simple_escape(in_byte_ff);
               mode_in     = MODE_PLAIN;
            end
         end
         MODE_U, MODE_X: begin
            if (need_met) begin
               if (!is_u) begin
                  dec_cnt     = 3'd1;
                  dec_byte[0] = acc_sum[7:0];
               end else if (is_high) begin
                  // park the high half, nothing out yet
                  held_in = acc_sum[15:0];
               end else begin
                  if (do_join) begin
                     held_in = 16'h0000;
                  end
                  dec_cnt  = u_cnt;
                  dec_byte = u_byte;
               end
               mode_in      = MODE_PLAIN;
               digit_cnt_in = 2'd0;
               acc_in       = '0;
            end else if (in_last_ff) begin
               // stream ends mid-escape: replay letter, buffered digits, this byte
               held_in     = 16'h0000;
               dec_byte[0] = is_u ? CH_U : CH_X;
               unique case (digit_cnt_ff)
                  2'd0: begin
                     dec_cnt     = 3'd2;
                     dec_byte[1] = in_byte_ff;
                  end
                  2'd1: begin
                     dec_cnt     = 3'd3;
                     dec_byte[1] = pend_ff[0];
                     dec_byte[2] = in_byte_ff;
                  end
                  default: begin
                     dec_cnt     = 3'd4;
                     dec_byte[1] = pend_ff[0];
                     dec_byte[2] = pend_ff[1];
                     dec_byte[3] = in_byte_ff;
                  end
               endcase
            end else begin
               pend_we      = 1'b1;
               digit_cnt_in = digit_cnt_ff + 2'd1;
               acc_in       = acc_sum;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
         end
      endcase

      if (in_last_ff) begin
         mode_in      = MODE_PLAIN;
         digit_cnt_in = 2'd0;
         acc_in       = '0;
         held_in      = 16'h0000;
      end
   end

   // ---------------- handshake ----------------
   assign rsp_valid    = ocnt_ff != 3'd0;
   assign rsp_out_byte = obuf_ff[0];
   assign rsp_run_last = ocnt_ff == 3'd1;
   assign rsp_take     = rsp_valid && !rsp_stall;

   assign buf_free  = (ocnt_ff == 3'd0) || (ocnt_ff == 3'd1 && !rsp_stall);
   assign move      = in_valid_ff && (buf_free || dec_cnt == 3'd0);
   assign req_stall = in_valid_ff && !move;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         digit_cnt_ff <= 2'd0;
         acc_ff       <= '0;
         held_ff      <= 16'h0000;
      end else if (move) begin
         mode_ff      <= mode_in;
         digit_cnt_ff <= digit_cnt_in;
         acc_ff       <= acc_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move && pend_we) begin
         pend_ff[digit_cnt_ff] <= in_byte_ff;
      end
   end

   // response buffer: loaded whole, drained from the front
   always_ff @(posedge clock) begin
      if (reset) begin
         ocnt_ff <= 3'd0;
      end else if (move && dec_cnt != 3'd0) begin
         ocnt_ff <= dec_cnt;
      end else if (rsp_take) begin
         ocnt_ff <= ocnt_ff - 3'd1;
      end
      if (move && dec_cnt != 3'd0) begin
         obuf_ff <= dec_byte;
      end else if (rsp_take) begin
         for (int i = 0; i < MAX_OUT - 1; i++) begin
            obuf_ff[i] <= obuf_ff[i+1];
         end
      end
   end

   // ---------------- checks ----------------
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (move && dec_cnt != 3'd0) |-> (ocnt_ff == 3'd0 || (ocnt_ff == 3'd1 && rsp_take)))
      else $error("response buffer loaded while bytes remain");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (move && in_last_ff) |=> (mode_ff == MODE_PLAIN && held_ff == 16'h0000 &&
                                digit_cnt_ff == 2'd0))
      else $error("decoder state not cleared after last byte");

   a_held_is_high: assert property (@(posedge clock) disable iff (reset)
      (held_ff != 16'h0000) |-> (held_ff[15:10] == 6'b110110))
      else $error("held value is not a high surrogate");

   a_x_digits: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_X) |-> (digit_cnt_ff <= 2'd1))
      else $error("too many digits buffered in hex byte escape");

   a_ocnt_range: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= 3'd4)
      else $error("response count out of range");

endmodule

// ----- test/decoded_byte_checker.sv -----
`timescale 1ns / 1ps
// Watches both channels of escape_sequence_decoder, predicts the decoded bytes
// of each request and compares them with the responses. Depends on esd_pkg.
module decoded_byte_checker
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_run_last,
   output int         fail_count,
   output int         pending_count
);

   localparam logic [7:0] DIGIT_0 = 8'h30;
   localparam logic [7:0] DIGIT_9 = 8'h39;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_F = 8'h66;
   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_F = 8'h46;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
   } decoded_byte_type;

   decoded_byte_type expected_bytes[$];
   decoded_byte_type want;
   int               mismatches = 0;

   // decoder state as predicted
   mode_type    mode;
   logic [1:0]  digits_taken;
   logic [20:0] code_acc;
   logic [15:0] held_high;
   logic [7:0]  digit_store [3];

   // non-hex bytes count with their raw value
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      if (c >= DIGIT_0 && c <= DIGIT_9) return c - DIGIT_0;
      if (c >= LOWER_A && c <= LOWER_F) return c - LOWER_A + 8'd10;
      if (c >= UPPER_A && c <= UPPER_F) return c - UPPER_A + 8'd10;
      return c;
   endfunction

   task automatic decode_request(input logic [7:0] b, input logic fin);
      logic [7:0]  produced[$];
      logic [7:0]  esc;
      logic [20:0] code;
      decoded_byte_type item;
      int need;
      int k;
      case (mode)
         MODE_PLAIN: begin
            if (b == CH_BACKSLASH && !fin) begin
               mode = MODE_ESC;
            end else begin
               held_high = '0;
               produced.push_back(b);
            end
         end
         MODE_ESC: begin
            if ((b == CH_U || b == CH_X) && !fin) begin
               mode = (b == CH_U) ? MODE_U : MODE_X;
               digits_taken = '0;
               code_acc = '0;
            end else begin
               held_high = '0;
               case (b)
                  CH_B:    esc = CTL_BS;
                  CH_T:    esc = CTL_TAB;
                  CH_N:    esc = CTL_LF;
                  CH_R:    esc = CTL_CR;
                  CH_F:    esc = CTL_FF;
                  CH_S:    esc = CTL_SPACE;
                  default: esc = b;
               endcase
               produced.push_back(esc);
               mode = MODE_PLAIN;
            end
         end
         default: begin
            need = (mode == MODE_U) ? 3 : 1;
            code_acc = {code_acc[16:0], 4'h0} + {13'd0, digit_value(b)};
            if (digits_taken >= need) begin
               if (mode == MODE_U) begin
                  code = code_acc;
                  if (code >= 21'hD800 && code < 21'hDC00) begin
                     held_high = code[15:0];
                  end else begin
                     if (code >= 21'hDC00 && code < 21'hE000 && held_high != '0) begin
                        code = 21'h10000 + {held_high[9:0], code[9:0]};
                        held_high = '0;
                     end
                     if (code < 21'h80) begin
                        produced.push_back(code[7:0]);
                     end else if (code < 21'h800) begin
                        produced.push_back({3'b110, code[10:6]});
                        produced.push_back({2'b10, code[5:0]});
                     end else if (code < 21'h10000) begin
                        produced.push_back({4'b1110, code[15:12]});
                        produced.push_back({2'b10, code[11:6]});
                        produced.push_back({2'b10, code[5:0]});
                     end else begin
                        produced.push_back({5'b11110, code[20:18]});
                        produced.push_back({2'b10, code[17:12]});
                        produced.push_back({2'b10, code[11:6]});
                        produced.push_back({2'b10, code[5:0]});
                     end
                  end
               end else begin
                  produced.push_back(code_acc[7:0]);
               end
               mode = MODE_PLAIN;
               digits_taken = '0;
               code_acc = '0;
            end else if (fin) begin
               // stream ends mid-escape: letter, buffered digits, then this byte
               held_high = '0;
               produced.push_back((mode == MODE_U) ? CH_U : CH_X);
               for (k = 0; k < digits_taken; k++) produced.push_back(digit_store[k]);
               produced.push_back(b);
            end else begin
               digit_store[digits_taken] = b;
               digits_taken = digits_taken + 2'd1;
            end
         end
      endcase
      if (fin) begin
         mode = MODE_PLAIN;
         digits_taken = '0;
         code_acc = '0;
         held_high = '0;
      end
      for (k = 0; k < produced.size(); k++) begin
         item.data = produced[k];
         item.run_last = (k == produced.size() - 1);
         expected_bytes.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode = MODE_PLAIN;
         digits_taken = '0;
         code_acc = '0;
         held_high = '0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) decode_request(req_in_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               $display("%0t: response %02h last=%0b with nothing expected",
                        $time, rsp_out_byte, rsp_run_last);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data || rsp_run_last !== want.run_last) begin
                  mismatches++;
                  $display("%0t: expected %02h last=%0b, got %02h last=%0b", $time,
                           want.data, want.run_last, rsp_out_byte, rsp_run_last);
               end
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_bytes.size();
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the escape_sequence_decoder testbench: clock, reset, request and response
// drivers and the verdict. Depends on esd_pkg, the decoder and decoded_byte_checker.
module tb_top;
   import esd_pkg::*;

   localparam int           CYCLE_LIMIT   = 200000;
   localparam int           DIRECTED_ITEMS = 25;
   localparam int           RANDOM_ITEMS  = 305;
   localparam int           LONG_HOLD     = 400;
   localparam logic [127:0] HEX_LOWER     = "0123456789abcdef";
   localparam logic [127:0] HEX_UPPER     = "0123456789ABCDEF";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   int         fail_count;
   int         pending_count;
   int         sent = 0;
   int         cycles = 0;
   bit         noisy = 1'b0;

   always #10 clock = ~clock;

   escape_sequence_decoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last)
   );

   decoded_byte_checker byte_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("escape_sequence_decoder: mismatch");
         $finish;
      end
   end

   // once noisy, any byte may end the stream early
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = ((sent / 50) % 3 == 2) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_last_byte <= fin || (noisy && $urandom_range(0, 29) == 0);
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic send_digits(input logic [15:0] v, input int count);
      logic [3:0] nib;
      logic [7:0] c;
      int i;
      for (i = count - 1; i >= 0; i--) begin
         nib = v[i*4 +: 4];
         c = $urandom_range(0, 1) ? HEX_UPPER[(15 - nib)*8 +: 8] : HEX_LOWER[(15 - nib)*8 +: 8];
         if (noisy && $urandom_range(0, 15) == 0) c = 8'($urandom_range(0, 255));
         send_byte(c, 1'b0);
      end
   endtask

   task automatic send_unicode(input logic [15:0] v);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte(CH_U, 1'b0);
      send_digits(v, 4);
   endtask

   initial begin : response_side
      int taken;
      int hold;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 60) hold = LONG_HOLD;
         else if ((taken / 40) % 3 == 1) hold = 0;
         else hold = $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : request_side
      logic [7:0]  c;
      logic [15:0] code;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // byte extremes, a simple escape, \x with a non-hex digit, a surrogate pair,
      // then a lone trailing backslash and a \u cut short by the end of stream
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte(CH_S, 1'b0);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte(CH_X, 1'b0);
      send_digits(16'h000F, 1);
      send_byte(8'hC7, 1'b0);
      send_unicode(16'hD83D);
      send_unicode(16'hDE00);
      send_byte(CH_BACKSLASH, 1'b1);
      send_byte(CH_BACKSLASH, 1'b0);
      send_byte(CH_U, 1'b0);
      send_digits(16'h0001, 1);
      send_byte(8'h32, 1'b1);

      noisy = 1'b1;
      while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1: send_byte(8'($urandom_range(0, 255)), 1'b0);
            2: begin
               case ($urandom_range(0, 7))
                  0:       c = CH_B;
                  1:       c = CH_T;
                  2:       c = CH_N;
                  3:       c = CH_R;
                  4:       c = CH_F;
                  5:       c = CH_S;
                  default: c = 8'($urandom_range(0, 255));
               endcase
               send_byte(CH_BACKSLASH, 1'b0);
               send_byte(c, 1'b0);
            end
            3: begin
               send_byte(CH_BACKSLASH, 1'b0);
               send_byte(CH_X, 1'b0);
               send_digits(16'($urandom_range(0, 255)), 2);
            end
            4, 5: begin
               case ($urandom_range(0, 2))
                  0:       code = 16'($urandom_range(0, 16'h007F));
                  1:       code = 16'($urandom_range(16'h0080, 16'h07FF));
                  default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
               endcase
               send_unicode(code);
            end
            6, 7: begin
               send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
               send_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            8: send_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            default: begin
               // held high surrogate dropped by whatever follows
               send_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
               send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         endcase
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      // long enough for any stray response to get past a receiver hold
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("escape_sequence_decoder: match");
      end else begin
         $display("escape_sequence_decoder: mismatch");
      end
      $finish;
   end

endmodule
